/* design/gaussian_elimination_solver_core_macros.svh */
// ----------------------------------------------------------------------------
// Gaussian elimination solver assertion macros
// Shared property wrappers for the checker of the solver core.
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_ELIMINATION_SOLVER_CORE_MACROS_SVH
`define GAUSSIAN_ELIMINATION_SOLVER_CORE_MACROS_SVH

// A property that must hold at every rising clock edge outside reset.
`define GES_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("gaussian elimination solver check failed");

// An implication that must hold in the cycle after its trigger.
`define GES_ASSERT_NEXT(label, clk, rst, trig, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) \
      else $error("gaussian elimination solver check failed");

`endif

/* design/ges_pkg.sv */
// ----------------------------------------------------------------------------
// Gaussian elimination solver package
// Sizes, shared types, status codes and the saturation helper.
// ----------------------------------------------------------------------------
package ges_pkg;

   localparam int DATA_WIDTH  = 32;
   localparam int MAX_ORDER   = 8;
   localparam int FRAC_BITS   = 16;
   localparam int ORDER_WIDTH = 4;
   localparam int ROW_W       = $clog2(MAX_ORDER);
   localparam int CNT_W       = $clog2(MAX_ORDER + 1);
   localparam int STORE_DEPTH = MAX_ORDER * (MAX_ORDER + 1);
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int LOAD_W      = $clog2(STORE_DEPTH + 1);
   localparam int PROD_W      = 2 * DATA_WIDTH;
   localparam int RND_W       = PROD_W - FRAC_BITS;
   localparam int DIVD_W      = DATA_WIDTH + FRAC_BITS;
   localparam int WIDE_W      = PROD_W + 2;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_PIVOT  = 2'd1;
   localparam logic [1:0] STATUS_OVF    = 2'd2;
   localparam logic [1:0] STATUS_UNUSED = 2'd3;

   localparam int FLAG_PIVOT = 0;
   localparam int FLAG_OVF   = 1;

   typedef logic signed [DATA_WIDTH-1:0] data_type;
   typedef logic signed [WIDE_W-1:0]     wide_type;

   typedef struct packed {
      data_type value;
      logic     ovf;
   } sat_type;

   typedef struct packed {
      logic     done;
      data_type value;
      logic     ovf;
      logic     zero;
   } div_result_type;

   typedef struct packed {
      logic                    done;
      logic signed [RND_W-1:0] value;
   } mul_result_type;

   // Clamp a wide signed value to the data range and report clamping.
   function automatic sat_type saturate(input wide_type v);
      wide_type hi;
      wide_type lo;
      sat_type  r;
      hi = {{(WIDE_W - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
      lo = {{(WIDE_W - DATA_WIDTH + 1){1'b1}}, {(DATA_WIDTH - 1){1'b0}}};
      if (v > hi) begin
         r.value = hi[DATA_WIDTH-1:0];
         r.ovf   = 1'b1;
      end else if (v < lo) begin
         r.value = lo[DATA_WIDTH-1:0];
         r.ovf   = 1'b1;
      end else begin
         r.value = v[DATA_WIDTH-1:0];
         r.ovf   = 1'b0;
      end
      return r;
   endfunction

endpackage

/* design/gaussian_elimination_solver_core.sv */
// ----------------------------------------------------------------------------
// Gaussian elimination solver core
// Loads an augmented matrix, triangularizes it and back-substitutes in Q16.16.
// ----------------------------------------------------------------------------
// The core takes an n-variable system (n from the order register, 1 to 8) as
// n*(n+1) coefficients, row by row, one per input transaction at one per
// cycle. After the last coefficient the input stalls while a small sequencer
// runs forward elimination and back substitution on one shared divider and
// one shared multiplier, then n result transactions come out in variable
// order with the last one marked. The divider retires one quotient bit a
// cycle. Each column update reads the pivot-row and target-row entries
// from the matrix memory, waits on the two-stage multiplier and writes the
// difference back to the matrix memory. Status is the same on every result
// of a run: zero pivot wins over overflow.
module gaussian_elimination_solver_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [31:0]                 req_coefficient,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [31:0]                 rsp_solution,
   output logic [2:0]                         rsp_variable_index,
   output logic                               rsp_last,
   output logic [1:0]                         rsp_status,
   input  logic                               csr_write_enable,
   input  logic [ges_pkg::ORDER_WIDTH-1:0]    csr_write_data
);
   import ges_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE, ST_E_PIV, ST_E_NUM, ST_E_DIV, ST_E_DWAIT, ST_E_RJK, ST_E_RIK,
      ST_E_MWAIT, ST_E_WR, ST_B_ROW, ST_B_RA, ST_B_MUL, ST_B_MWAIT, ST_B_RB,
      ST_B_RD, ST_B_DIV, ST_B_DWAIT, ST_OUT
   } state_type;

   state_type                state_ff;
   logic [ORDER_WIDTH-1:0]   order_ff;
   logic [LOAD_W-1:0]        load_count_ff;
   logic [1:0]               flags_ff;
   logic [CNT_W-1:0]         i_ff;
   logic [CNT_W-1:0]         j_ff;
   logic [CNT_W-1:0]         k_ff;
   logic [ROW_W-1:0]         out_idx_ff;
   data_type                 piv_ff;
   data_type                 c_ff;
   data_type                 p_ff;
   data_type                 rhs_ff;
   logic signed [PROD_W-1:0] sum_ff;
   data_type                 sol_ff [MAX_ORDER];

   // Matrix memory: one write port and one registered read port.
   data_type                 mem [STORE_DEPTH];
   data_type                 rdata_ff;
   logic                     mem_we;
   logic                     mem_re;
   logic [ADDR_W-1:0]        mem_wa;
   logic [ADDR_W-1:0]        mem_ra;
   data_type                 mem_wd;

   logic [CNT_W-1:0]         n_eff;
   logic [CNT_W:0]           width;
   logic [LOAD_W-1:0]        total;
   logic                     req_accept;
   logic                     rsp_accept;
   logic                     div_start;
   logic                     mul_start;
   data_type                 div_num;
   data_type                 div_den;
   data_type                 mul_a;
   data_type                 mul_b;
   div_result_type           div_res;
   mul_result_type           mul_res;
   sat_type                  p_sat;
   sat_type                  sub_sat;
   sat_type                  rhs_sat;

   function automatic logic [ADDR_W-1:0] addr_of(input logic [CNT_W-1:0] row,
                                                  input logic [CNT_W-1:0] col,
                                                  input logic [CNT_W:0]   w);
      return ADDR_W'(row * w + col);
   endfunction

   // Out-of-range orders are clamped: zero acts as one, large values as the maximum.
   always_comb begin
      if (order_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (order_ff > ORDER_WIDTH'(MAX_ORDER)) begin
         n_eff = CNT_W'(MAX_ORDER);
      end else begin
         n_eff = CNT_W'(order_ff);
      end
      width = {1'b0, n_eff} + 1'b1;
      total = LOAD_W'(n_eff * width);
   end

   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = (state_ff == ST_OUT);

   assign p_sat   = saturate(wide_type'(mul_res.value));
   assign sub_sat = saturate(wide_type'(rdata_ff) - wide_type'(p_ff));
   assign rhs_sat = saturate(wide_type'(rdata_ff) - wide_type'(sum_ff));

   // Memory port control follows the sequencer state.
   always_comb begin
      mem_we = 1'b0;
      mem_re = 1'b0;
      mem_wa = load_count_ff[ADDR_W-1:0];
      mem_wd = req_coefficient;
      mem_ra = '0;
      unique case (state_ff)
         ST_IDLE: begin
            mem_we = req_accept && (load_count_ff < LOAD_W'(STORE_DEPTH));
         end
         ST_E_PIV: begin
            mem_re = 1'b1;
            mem_ra = addr_of(j_ff, j_ff, width);
         end
         ST_E_NUM: begin
            mem_re = 1'b1;
            mem_ra = addr_of(i_ff, j_ff, width);
         end
         ST_E_RJK: begin
            mem_re = 1'b1;
            mem_ra = addr_of(j_ff, k_ff, width);
         end
         ST_E_RIK: begin
            mem_re = 1'b1;
            mem_ra = addr_of(i_ff, k_ff, width);
         end
         ST_E_WR: begin
            mem_we = 1'b1;
            mem_wa = addr_of(i_ff, k_ff, width);
            mem_wd = sub_sat.value;
         end
         ST_B_RA: begin
            mem_re = 1'b1;
            mem_ra = addr_of(i_ff, k_ff, width);
         end
         ST_B_RB: begin
            mem_re = 1'b1;
            mem_ra = addr_of(i_ff, n_eff, width);
         end
         ST_B_RD: begin
            mem_re = 1'b1;
            mem_ra = addr_of(i_ff, i_ff, width);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_ra];
      end
   end

   // The divider serves both the elimination factors and the final solutions.
   assign div_start = (state_ff == ST_E_DIV) || (state_ff == ST_B_DIV);
   assign div_num   = (state_ff == ST_E_DIV) ? rdata_ff : rhs_ff;
   assign div_den   = (state_ff == ST_E_DIV) ? piv_ff : rdata_ff;

   // The multiplier serves the row updates and the back-substitution sums.
   assign mul_start = (state_ff == ST_E_RIK) || (state_ff == ST_B_MUL);
   assign mul_a     = (state_ff == ST_E_RIK) ? c_ff : rdata_ff;
   assign mul_b     = (state_ff == ST_E_RIK) ? rdata_ff : sol_ff[k_ff[ROW_W-1:0]];

   ges_divider u_divider (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (div_num),
      .den    (div_den),
      .result (div_res)
   );

   ges_multiplier u_multiplier (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .a      (mul_a),
      .b      (mul_b),
      .result (mul_res)
   );

   // Sequencer. In back substitution k_ff walks the known solutions.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         order_ff      <= ORDER_WIDTH'(1);
         load_count_ff <= '0;
         flags_ff      <= '0;
         out_idx_ff    <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  if (load_count_ff + 1'b1 == total) begin
                     load_count_ff <= '0;
                     if (n_eff == CNT_W'(1)) begin
                        i_ff     <= '0;
                        state_ff <= ST_B_ROW;
                     end else begin
                        j_ff     <= '0;
                        i_ff     <= CNT_W'(1);
                        state_ff <= ST_E_PIV;
                     end
                  end else begin
                     load_count_ff <= load_count_ff + 1'b1;
                  end
               end
            end
            ST_E_PIV: state_ff <= ST_E_NUM;
            ST_E_NUM: begin
               piv_ff   <= rdata_ff;
               state_ff <= ST_E_DIV;
            end
            ST_E_DIV: state_ff <= ST_E_DWAIT;
            ST_E_DWAIT: begin
               if (div_res.done) begin
                  c_ff     <= div_res.value;
                  flags_ff <= flags_ff | {div_res.ovf, div_res.zero};
                  k_ff     <= '0;
                  state_ff <= ST_E_RJK;
               end
            end
            ST_E_RJK: state_ff <= ST_E_RIK;
            ST_E_RIK: state_ff <= ST_E_MWAIT;
            ST_E_MWAIT: begin
               if (mul_res.done) begin
                  p_ff               <= p_sat.value;
                  flags_ff[FLAG_OVF] <= flags_ff[FLAG_OVF] | p_sat.ovf;
                  state_ff           <= ST_E_WR;
               end
            end
            ST_E_WR: begin
               flags_ff[FLAG_OVF] <= flags_ff[FLAG_OVF] | sub_sat.ovf;
               if (k_ff == n_eff) begin
                  if (i_ff + 1'b1 == n_eff) begin
                     if (CNT_W'(j_ff + 2'd2) >= n_eff) begin
                        i_ff     <= n_eff - 1'b1;
                        state_ff <= ST_B_ROW;
                     end else begin
                        j_ff     <= j_ff + 1'b1;
                        i_ff     <= CNT_W'(j_ff + 2'd2);
                        state_ff <= ST_E_PIV;
                     end
                  end else begin
                     i_ff     <= i_ff + 1'b1;
                     state_ff <= ST_E_PIV;
                  end
               end else begin
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= ST_E_RJK;
               end
            end
            ST_B_ROW: begin
               sum_ff <= '0;
               k_ff   <= i_ff + 1'b1;
               if (i_ff + 1'b1 == n_eff) begin
                  state_ff <= ST_B_RB;
               end else begin
                  state_ff <= ST_B_RA;
               end
            end
            ST_B_RA:  state_ff <= ST_B_MUL;
            ST_B_MUL: state_ff <= ST_B_MWAIT;
            ST_B_MWAIT: begin
               if (mul_res.done) begin
                  sum_ff <= sum_ff + PROD_W'(mul_res.value);
                  k_ff   <= k_ff + 1'b1;
                  if (k_ff + 1'b1 == n_eff) begin
                     state_ff <= ST_B_RB;
                  end else begin
                     state_ff <= ST_B_RA;
                  end
               end
            end
            ST_B_RB: state_ff <= ST_B_RD;
            ST_B_RD: begin
               rhs_ff             <= rhs_sat.value;
               flags_ff[FLAG_OVF] <= flags_ff[FLAG_OVF] | rhs_sat.ovf;
               state_ff           <= ST_B_DIV;
            end
            ST_B_DIV: state_ff <= ST_B_DWAIT;
            ST_B_DWAIT: begin
               if (div_res.done) begin
                  sol_ff[i_ff[ROW_W-1:0]] <= div_res.value;
                  flags_ff <= flags_ff | {div_res.ovf, div_res.zero};
                  if (i_ff == '0) begin
                     out_idx_ff <= '0;
                     state_ff   <= ST_OUT;
                  end else begin
                     i_ff     <= i_ff - 1'b1;
                     state_ff <= ST_B_ROW;
                  end
               end
            end
            ST_OUT: begin
               if (rsp_accept) begin
                  if (rsp_last) begin
                     load_count_ff <= '0;
                     flags_ff      <= '0;
                     state_ff      <= ST_IDLE;
                  end else begin
                     out_idx_ff <= out_idx_ff + 1'b1;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
         // Writing the order discards any partly loaded matrix.
         if (csr_write_enable) begin
            order_ff      <= csr_write_data;
            load_count_ff <= '0;
            flags_ff      <= '0;
         end
      end
   end

   always_comb begin
      rsp_solution       = sol_ff[out_idx_ff];
      rsp_variable_index = 3'(out_idx_ff);
      rsp_last           = (CNT_W'(out_idx_ff) + 1'b1 == n_eff);
      if (flags_ff[FLAG_PIVOT]) begin
         rsp_status = STATUS_PIVOT;
      end else if (flags_ff[FLAG_OVF]) begin
         rsp_status = STATUS_OVF;
      end else begin
         rsp_status = STATUS_OK;
      end
   end

endmodule

/* design/ges_divider.sv */
// ----------------------------------------------------------------------------
// Fixed-point divider
// Restoring divider, one quotient bit per cycle, computing num*2^16/den.
// ----------------------------------------------------------------------------
module ges_divider (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  ges_pkg::data_type       num,
   input  ges_pkg::data_type       den,
   output ges_pkg::div_result_type result
);
   import ges_pkg::*;

   localparam int STEP_W = $clog2(DIVD_W + 1);

   logic                  busy_ff;
   logic                  fin_ff;
   logic [STEP_W-1:0]     step_ff;
   logic [DIVD_W-1:0]     dvd_ff;
   logic [DATA_WIDTH:0]   rem_ff;
   logic [DATA_WIDTH-1:0] dsr_ff;
   logic                  neg_ff;
   div_result_type        result_ff;

   logic [DATA_WIDTH-1:0] num_mag;
   logic [DATA_WIDTH-1:0] den_mag;
   logic [DATA_WIDTH:0]   rem_sh;
   logic                  qbit;
   wide_type              quo_wide;
   sat_type               quo_sat;

   always_comb begin
      num_mag  = num[DATA_WIDTH-1] ? DATA_WIDTH'(-num) : DATA_WIDTH'(num);
      den_mag  = den[DATA_WIDTH-1] ? DATA_WIDTH'(-den) : DATA_WIDTH'(den);
      rem_sh   = {rem_ff[DATA_WIDTH-1:0], dvd_ff[DIVD_W-1]};
      qbit     = (rem_sh >= {1'b0, dsr_ff});
      quo_wide = neg_ff ? -wide_type'({1'b0, dvd_ff}) : wide_type'({1'b0, dvd_ff});
      quo_sat  = saturate(quo_wide);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         fin_ff         <= 1'b0;
         result_ff.done <= 1'b0;
      end else begin
         result_ff.done <= 1'b0;
         fin_ff         <= 1'b0;
         if (start) begin
            if (den == '0) begin
               result_ff.done  <= 1'b1;
               result_ff.value <= '0;
               result_ff.ovf   <= 1'b0;
               result_ff.zero  <= 1'b1;
            end else begin
               busy_ff <= 1'b1;
               step_ff <= STEP_W'(DIVD_W);
               dvd_ff  <= {num_mag, {FRAC_BITS{1'b0}}};
               dsr_ff  <= den_mag;
               rem_ff  <= '0;
               neg_ff  <= num[DATA_WIDTH-1] ^ den[DATA_WIDTH-1];
            end
         end else if (busy_ff) begin
            rem_ff  <= qbit ? (rem_sh - {1'b0, dsr_ff}) : rem_sh;
            dvd_ff  <= {dvd_ff[DIVD_W-2:0], qbit};
            step_ff <= step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
               fin_ff  <= 1'b1;
            end
         end else if (fin_ff) begin
            result_ff.done  <= 1'b1;
            result_ff.value <= quo_sat.value;
            result_ff.ovf   <= quo_sat.ovf;
            result_ff.zero  <= 1'b0;
         end
      end
   end

   assign result = result_ff;

endmodule

/* design/ges_multiplier.sv */
// ----------------------------------------------------------------------------
// Fixed-point multiplier
// Two-stage signed product with round-to-nearest removal of fraction bits.
// ----------------------------------------------------------------------------
module ges_multiplier (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  ges_pkg::data_type       a,
   input  ges_pkg::data_type       b,
   output ges_pkg::mul_result_type result
);
   import ges_pkg::*;

   logic                     prod_v_ff;
   logic signed [PROD_W-1:0] prod_ff;
   mul_result_type           result_ff;
   logic signed [PROD_W-1:0] prod_rnd;

   assign prod_rnd = prod_ff + (PROD_W'(1) <<< (FRAC_BITS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_v_ff      <= 1'b0;
         result_ff.done <= 1'b0;
      end else begin
         prod_v_ff      <= start;
         result_ff.done <= prod_v_ff;
      end
      prod_ff         <= PROD_W'(a) * PROD_W'(b);
      result_ff.value <= prod_rnd[PROD_W-1:FRAC_BITS];
   end

   assign result = result_ff;

endmodule

/* design/ges_checker.sv */
// ----------------------------------------------------------------------------
// Gaussian elimination solver checker
// Port-level checks on the result stream, bound to the solver core.
// ----------------------------------------------------------------------------
`include "gaussian_elimination_solver_core_macros.svh"

module ges_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic signed [31:0]              req_coefficient,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic signed [31:0]              rsp_solution,
   input logic [2:0]                      rsp_variable_index,
   input logic                            rsp_last,
   input logic [1:0]                      rsp_status,
   input logic                            csr_write_enable,
   input logic [ges_pkg::ORDER_WIDTH-1:0] csr_write_data
);
   import ges_pkg::*;

   // A stalled result transaction holds its payload.
   `GES_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_solution) && $stable(rsp_variable_index))

   // The input stays stalled while results are being delivered.
   `GES_ASSERT(a_busy_while_out, clock, reset, rsp_valid |-> req_stall)

   // Results of one run come out in ascending variable order without gaps.
   `GES_ASSERT_NEXT(a_index_steps, clock, reset, rsp_valid && !rsp_stall && !rsp_last, rsp_valid && rsp_variable_index == 3'($past(rsp_variable_index) + 1'b1))

   // The first result of a run is for variable zero.
   `GES_ASSERT(a_first_index, clock, reset, $rose(rsp_valid) |-> rsp_variable_index == '0)

   // The run status never takes the unused code.
   `GES_ASSERT(a_status_code, clock, reset, rsp_valid |-> rsp_status != STATUS_UNUSED)

endmodule

bind gaussian_elimination_solver_core ges_checker u_ges_checker (.*);
